@@ hdl/name_token_scanner_unit_macros.svh @@
// Assertion macros used by the name token scanner RTL.
// Expects clk and rst_n to be visible where the macros are used.
`ifndef NAME_TOKEN_SCANNER_UNIT_MACROS_SVH
`define NAME_TOKEN_SCANNER_UNIT_MACROS_SVH

// same-cycle implication, disabled while in reset
`define NTS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while in reset
`define NTS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/nts_pkg.sv @@
// Shared types, constants and byte classifiers for the name token scanner.
// No dependencies; imported by every scanner module.
`timescale 1ns / 1ps

package nts_pkg;

  localparam int BYTE_W         = 8;
  localparam int LEN_W          = 8;
  localparam int OUT_OFFSET_W   = 24;
  localparam int OFFSET_BITS_DEF = 24;
  localparam int CFG_IDX_W      = 1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_LENGTH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LENGTH = 1'b1;

  localparam logic [LEN_W-1:0] MIN_LENGTH_RST = 8'd4;
  localparam logic [LEN_W-1:0] MAX_LENGTH_RST = 8'd200;
  localparam logic [LEN_W-1:0] RUN_COUNT_MAX  = 8'd255;

  localparam logic [BYTE_W-1:0] CHAR_UNDERSCORE = 8'h5F;
  localparam logic [BYTE_W-1:0] CHAR_QUESTION   = 8'h3F;
  localparam logic [BYTE_W-1:0] CHAR_AT         = 8'h40;
  localparam logic [BYTE_W-1:0] CHAR_DOLLAR     = 8'h24;
  localparam logic [BYTE_W-1:0] CHAR_LOWER_A    = 8'h61;
  localparam logic [BYTE_W-1:0] CHAR_LOWER_Z    = 8'h7A;
  localparam logic [BYTE_W-1:0] CHAR_UPPER_A    = 8'h41;
  localparam logic [BYTE_W-1:0] CHAR_UPPER_Z    = 8'h5A;
  localparam logic [BYTE_W-1:0] CHAR_DIGIT_0    = 8'h30;
  localparam logic [BYTE_W-1:0] CHAR_DIGIT_9    = 8'h39;

  typedef struct packed {
    logic [BYTE_W-1:0] next_byte;
    logic              last_byte;
  } in_beat_t;

  typedef struct packed {
    logic [OUT_OFFSET_W-1:0] start_offset;
    logic [LEN_W-1:0]        name_length;
  } out_beat_t;

  // result of one scanned byte
  typedef struct packed {
    logic      emit;
    out_beat_t beat;
  } scan_res_t;

  function automatic logic is_lower(input logic [BYTE_W-1:0] c);
    return (c >= CHAR_LOWER_A) && (c <= CHAR_LOWER_Z);
  endfunction

  function automatic logic is_upper(input logic [BYTE_W-1:0] c);
    return (c >= CHAR_UPPER_A) && (c <= CHAR_UPPER_Z);
  endfunction

  function automatic logic is_start_byte(input logic [BYTE_W-1:0] c);
    return (c == CHAR_UNDERSCORE) || (c == CHAR_QUESTION) || (c == CHAR_AT) ||
           is_lower(c) || is_upper(c);
  endfunction

  function automatic logic is_name_byte(input logic [BYTE_W-1:0] c);
    return is_start_byte(c) || ((c >= CHAR_DIGIT_0) && (c <= CHAR_DIGIT_9)) ||
           (c == CHAR_DOLLAR);
  endfunction

  function automatic logic is_good_first(input logic [BYTE_W-1:0] c);
    return (c == CHAR_UNDERSCORE) || (c == CHAR_QUESTION) || is_lower(c);
  endfunction

endpackage

@@ hdl/nts_run_tracker.sv @@
// Run state and judging logic of the name token scanner.
// Depends on nts_pkg; instantiated by name_token_scanner_unit.
`timescale 1ns / 1ps

module nts_run_tracker
  import nts_pkg::*;
#(
  parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step,
  input  in_beat_t         beat,
  input  logic [LEN_W-1:0] min_len,
  input  logic [LEN_W-1:0] max_len,
  output scan_res_t        res
);

  logic                   in_run_r, in_run_nxt;
  logic [OFFSET_BITS-1:0] run_start_r, run_start_nxt;
  logic [LEN_W-1:0]       run_count_r, run_count_nxt;
  logic                   first_good_r, first_good_nxt;
  logic                   second_lower_r, second_lower_nxt;
  logic [OFFSET_BITS-1:0] byte_pos_r, byte_pos_nxt;

  logic                   name_b, start_b, close_now, extend, open_run, run_after;
  logic [LEN_W-1:0]       cnt_after;
  logic [OFFSET_BITS-1:0] start_after;
  logic                   fg_after, sl_after;

  logic                   j_sel, j_run, j_fg, j_sl;
  logic [LEN_W-1:0]       j_cnt;
  logic [OFFSET_BITS-1:0] j_start;
  logic [OUT_OFFSET_W-1:0] j_start_out;

  // classify the byte against the open run
  always_comb begin
    name_b    = is_name_byte(beat.next_byte);
    start_b   = is_start_byte(beat.next_byte);
    close_now = in_run_r && !name_b;
    extend    = in_run_r && name_b;
    open_run  = !in_run_r && start_b;
    run_after = extend || open_run;
    if (extend) begin
      cnt_after   = (run_count_r < RUN_COUNT_MAX) ? run_count_r + 1'b1 : run_count_r;
      start_after = run_start_r;
      fg_after    = first_good_r;
      sl_after    = second_lower_r ||
                    ((run_count_r == LEN_W'(1)) && is_lower(beat.next_byte));
    end else begin
      cnt_after   = LEN_W'(1);
      start_after = byte_pos_r;
      fg_after    = is_good_first(beat.next_byte);
      sl_after    = 1'b0;
    end
  end

  // pick the run to judge: the one this byte ends, or the one ended by the last byte
  always_comb begin
    j_sel   = close_now;
    j_run   = close_now || (beat.last_byte && run_after);
    j_cnt   = j_sel ? run_count_r    : cnt_after;
    j_start = j_sel ? run_start_r    : start_after;
    j_fg    = j_sel ? first_good_r   : fg_after;
    j_sl    = j_sel ? second_lower_r : sl_after;
  end

  // offset narrowed or widened to the result field
  generate
    if (OFFSET_BITS >= OUT_OFFSET_W) begin : g_trunc
      assign j_start_out = j_start[OUT_OFFSET_W-1:0];
    end else begin : g_ext
      assign j_start_out = {{(OUT_OFFSET_W-OFFSET_BITS){1'b0}}, j_start};
    end
  endgenerate

  // length window, saturated-count cap and first/second byte rule
  always_comb begin
    res.emit = j_run && (j_cnt < RUN_COUNT_MAX) && (j_cnt >= min_len) &&
               (j_cnt <= max_len) && (j_fg || j_sl);
    res.beat.start_offset = j_start_out;
    res.beat.name_length  = j_cnt;
  end

  // next run state
  always_comb begin
    in_run_nxt       = 1'b0;
    run_start_nxt    = '0;
    run_count_nxt    = '0;
    first_good_nxt   = 1'b0;
    second_lower_nxt = 1'b0;
    byte_pos_nxt     = '0;
    if (!beat.last_byte) begin
      byte_pos_nxt = OFFSET_BITS'(byte_pos_r + 1'b1);
      if (run_after) begin
        in_run_nxt       = 1'b1;
        run_start_nxt    = start_after;
        run_count_nxt    = cnt_after;
        first_good_nxt   = fg_after;
        second_lower_nxt = sl_after;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_run_r       <= 1'b0;
      run_start_r    <= '0;
      run_count_r    <= '0;
      first_good_r   <= 1'b0;
      second_lower_r <= 1'b0;
      byte_pos_r     <= '0;
    end else if (step) begin
      in_run_r       <= in_run_nxt;
      run_start_r    <= run_start_nxt;
      run_count_r    <= run_count_nxt;
      first_good_r   <= first_good_nxt;
      second_lower_r <= second_lower_nxt;
      byte_pos_r     <= byte_pos_nxt;
    end
  end

endmodule

@@ hdl/nts_out_reg.sv @@
// Result register of the name token scanner: holds one beat until taken.
// Depends on nts_pkg; instantiated by name_token_scanner_unit.
`timescale 1ns / 1ps

module nts_out_reg
  import nts_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      load,
  input  out_beat_t load_beat,
  output logic      room,
  output logic      out_valid,
  input  logic      out_stall,
  output out_beat_t out_beat
);

  logic      vld_r, vld_nxt;
  out_beat_t beat_r;

  // free when empty or when the held beat leaves this cycle
  assign room = !vld_r || !out_stall;

  always_comb begin
    vld_nxt = vld_r;
    if (load) begin
      vld_nxt = 1'b1;
    end else if (vld_r && !out_stall) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (load) begin
      beat_r <= load_beat;
    end
  end

  assign out_valid = vld_r;
  assign out_beat  = beat_r;

endmodule

@@ hdl/name_token_scanner_unit.sv @@
// Name token scanner top level: input register, run tracker, result register.
// Depends on nts_pkg, nts_run_tracker, nts_out_reg and the macros header.
//
// Scans a byte stream one byte per beat and reports identifier-like runs as
// (start offset, length) beats. A byte is registered on accept and classified
// in the following cycle. When the byte stage advances, the byte is folded into
// the run state, and a reported name lands in the result register at that same
// edge and is offered from there. One byte is accepted every cycle; the byte
// stage only holds when it has a name to hand over while the result register
// is full and stalled. Offsets count from zero and restart after a beat with
// last_byte set.
// min_length and max_length are to be written only while the block is idle.
`timescale 1ns / 1ps
`include "name_token_scanner_unit_macros.svh"

module name_token_scanner_unit
  import nts_pkg::*;
#(
  parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // byte input
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_beat_t             in_beat,
  // name results
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_beat_t            out_beat,
  // configuration
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [LEN_W-1:0]     cfg_wdata
);

  logic             stg_vld_r, stg_vld_nxt;
  in_beat_t         stg_beat_r;
  logic             stg_adv, in_fire, out_room;
  scan_res_t        scan_res;
  logic [LEN_W-1:0] min_len_r, max_len_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_len_r <= MIN_LENGTH_RST;
      max_len_r <= MAX_LENGTH_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_MIN_LENGTH: min_len_r <= cfg_wdata;
        CFG_MAX_LENGTH: max_len_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // byte stage handshake
  assign stg_adv  = stg_vld_r && (!scan_res.emit || out_room);
  assign in_stall = stg_vld_r && !stg_adv;
  assign in_fire  = in_valid && !in_stall;

  always_comb begin
    stg_vld_nxt = stg_vld_r;
    if (in_fire) begin
      stg_vld_nxt = 1'b1;
    end else if (stg_adv) begin
      stg_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_vld_r <= 1'b0;
    end else begin
      stg_vld_r <= stg_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      stg_beat_r <= in_beat;
    end
  end

  // run tracking and judging
  nts_run_tracker #(
    .OFFSET_BITS(OFFSET_BITS)
  ) u_tracker (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (stg_adv),
    .beat   (stg_beat_r),
    .min_len(min_len_r),
    .max_len(max_len_r),
    .res    (scan_res)
  );

  // result register
  nts_out_reg u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (stg_adv && scan_res.emit),
    .load_beat(scan_res.beat),
    .room     (out_room),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_beat (out_beat)
  );

  // checks
  `NTS_ASSERT_NOW(a_hold_only_when_blocked, stg_vld_r && !stg_adv, out_valid && out_stall,
    "byte stage held without a blocked result")
  `NTS_ASSERT_NOW(a_fire_frees_stage, in_fire, !stg_vld_r || stg_adv,
    "byte accepted over an occupied stage")
  `NTS_ASSERT_NOW(a_len_in_range, out_valid,
    (out_beat.name_length != '0) && (out_beat.name_length != RUN_COUNT_MAX),
    "reported name length out of range")
  `NTS_ASSERT_NOW(a_rise_after_step, $rose(out_valid), $past(stg_adv),
    "result appeared without a scanned byte")

endmodule

@@ tb/nts_name_checker.sv @@
`timescale 1ns / 1ps
// Name checker for the token scanner bench: predicts the reported names from
// accepted byte beats and compares them with the beats on the result channel.
// Depends on nts_pkg for the beat types and the register indexes.

module nts_name_checker
  import nts_pkg::*;
#(
  parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  in_beat_t             in_beat,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  out_beat_t            out_beat,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [LEN_W-1:0]     cfg_wdata,
  output int                   names_pending,
  output int                   fail_count
);

  localparam logic [7:0] FLOOR_AT_RESET = 8'd4;
  localparam logic [7:0] ROOF_AT_RESET  = 8'd200;
  localparam logic [7:0] LEN_CEILING    = 8'd255;

  // register copies
  logic [7:0] len_floor = FLOOR_AT_RESET;
  logic [7:0] len_roof  = ROOF_AT_RESET;

  // open run and stream position
  logic                   run_open;
  logic [OFFSET_BITS-1:0] run_origin;
  logic [7:0]             run_len;
  logic                   lead_ok;
  logic                   second_lc;
  logic [OFFSET_BITS-1:0] stream_pos;

  // names predicted but not yet seen on the result channel
  out_beat_t names_due[$];

  function automatic logic lc_letter(input logic [7:0] c);
    return (c >= "a") && (c <= "z");
  endfunction

  function automatic logic uc_letter(input logic [7:0] c);
    return (c >= "A") && (c <= "Z");
  endfunction

  function automatic logic opens_name(input logic [7:0] c);
    return lc_letter(c) || uc_letter(c) || (c == "_") || (c == "?") || (c == "@");
  endfunction

  function automatic logic extends_name(input logic [7:0] c);
    return opens_name(c) || ((c >= "0") && (c <= "9")) || (c == "$");
  endfunction

  task automatic report(input string what, input int unsigned got, input int unsigned want);
    $display("[%0t] name mismatch: %s got %0d want %0d", $time, what, got, want);
    fail_count++;
  endtask

  task automatic drop_run();
    run_open   = 1'b0;
    run_origin = '0;
    run_len    = '0;
    lead_ok    = 1'b0;
    second_lc  = 1'b0;
  endtask

  // judge the run that just ended and queue it if it passes
  task automatic close_run();
    out_beat_t found;
    if (run_open && (run_len != LEN_CEILING) && (run_len >= len_floor) &&
        (run_len <= len_roof) && (lead_ok || second_lc)) begin
      found.start_offset = OUT_OFFSET_W'(run_origin);
      found.name_length  = run_len;
      names_due = {names_due, found};
    end
    drop_run();
  endtask

  // fold one accepted byte into the run state
  task automatic scan_byte(input in_beat_t b);
    if (run_open) begin
      if (extends_name(b.next_byte)) begin
        if ((run_len == 8'd1) && lc_letter(b.next_byte)) second_lc = 1'b1;
        if (run_len != LEN_CEILING) run_len = run_len + 8'd1;
      end else begin
        close_run();
      end
    end else if (opens_name(b.next_byte)) begin
      run_open   = 1'b1;
      run_origin = stream_pos;
      run_len    = 8'd1;
      lead_ok    = lc_letter(b.next_byte) || (b.next_byte == "_") || (b.next_byte == "?");
      second_lc  = 1'b0;
    end
    // stream end closes any run and restarts the offsets
    if (b.last_byte) begin
      if (run_open) close_run();
      stream_pos = '0;
    end else begin
      stream_pos = stream_pos + 1'b1;
    end
  endtask

  always @(posedge clk) begin
    out_beat_t want;
    if (!rst_n) begin
      len_floor  = FLOOR_AT_RESET;
      len_roof   = ROOF_AT_RESET;
      stream_pos = '0;
      drop_run();
      names_due.delete();
    end else begin
      // result beat against the oldest predicted name
      if (out_valid && !out_stall) begin
        if (names_due.size() == 0) begin
          report("unexpected name beat, offset", out_beat.start_offset, 0);
        end else begin
          want = names_due.pop_front();
          if (out_beat.start_offset !== want.start_offset)
            report("start_offset", out_beat.start_offset, want.start_offset);
          if (out_beat.name_length !== want.name_length)
            report("name_length", out_beat.name_length, want.name_length);
        end
      end
      // register writes
      if (cfg_we) begin
        case (cfg_idx)
          CFG_MIN_LENGTH: len_floor = cfg_wdata;
          CFG_MAX_LENGTH: len_roof  = cfg_wdata;
          default: ;
        endcase
      end
      // byte beat
      if (in_valid && !in_stall) scan_byte(in_beat);
    end
    names_pending <= names_due.size();
  end

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// Top of the token scanner bench: clock, reset, byte stimulus, result stalls
// and register phases. Depends on nts_pkg, name_token_scanner_unit and nts_name_checker.

module tb_top;
  import nts_pkg::*;

  localparam int N_PHASES       = 7;
  localparam int PHASE_BYTES    = 130;
  localparam int SETTLE_CYCLES  = 8;
  localparam int RX_HOLD_CYCLES = 120;

  typedef enum int {
    END_STOP,
    END_STOP_LAST,
    END_ON_LAST_BYTE
  } name_end_e;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  in_beat_t             in_beat = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_beat_t            out_beat;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = CFG_MIN_LENGTH;
  logic [LEN_W-1:0]     cfg_wdata = '0;

  int names_pending;
  int fail_count;

  // idling switches and the long result hold-off request
  bit tx_idle_en = 1'b1;
  bit rx_idle_en = 1'b1;
  bit rx_hold_req = 1'b0;
  int name_bytes = 0;

  // length bounds per phase, reset values and extremes among them
  int ph_min [N_PHASES] = '{1, 4, 1, 255, 254, 3, 9};
  int ph_max [N_PHASES] = '{254, 200, 1, 254, 254, 8, 2};

  name_token_scanner_unit uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_beat   (in_beat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_beat  (out_beat),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  nts_name_checker #(.OFFSET_BITS(OFFSET_BITS_DEF)) u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_beat       (in_beat),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_beat      (out_beat),
    .cfg_we        (cfg_we),
    .cfg_idx       (cfg_idx),
    .cfg_wdata     (cfg_wdata),
    .names_pending (names_pending),
    .fail_count    (fail_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // offer one byte beat and wait for it to be taken
  task automatic send_byte(input logic [7:0] b, input logic last);
    int unsigned gap;
    gap = tx_idle_en ? $urandom_range(14, 0) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_beat  <= '{next_byte: b, last_byte: last};
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // bytes that never belong to a name
  function automatic logic [7:0] pick_stop_byte();
    case ($urandom_range(5, 0))
      0:       return 8'($urandom_range(8'h23, 8'h00));
      1:       return 8'($urandom_range(8'h2F, 8'h25));
      2:       return 8'($urandom_range(8'h3E, 8'h3A));
      3:       return 8'($urandom_range(8'h5E, 8'h5B));
      4:       return 8'h60;
      default: return 8'($urandom_range(8'hFF, 8'h7B));
    endcase
  endfunction

  function automatic logic [7:0] pick_open_byte(input logic good);
    case ($urandom_range(3, 0))
      0, 1:    return good ? 8'($urandom_range("z", "a")) : 8'($urandom_range("Z", "A"));
      2:       return good ? 8'("_") : 8'($urandom_range("Z", "A"));
      default: return good ? 8'("?") : 8'("@");
    endcase
  endfunction

  function automatic logic [7:0] pick_tail_byte();
    case ($urandom_range(3, 0))
      0: return 8'($urandom_range("z", "a"));
      1: return 8'($urandom_range("Z", "A"));
      2: return 8'($urandom_range("9", "0"));
      default: begin
        case ($urandom_range(3, 0))
          0:       return 8'("_");
          1:       return 8'("@");
          2:       return 8'("?");
          default: return 8'("$");
        endcase
      end
    endcase
  endfunction

  // lengths cluster around the bounds where that stays cheap
  function automatic int pick_len(input int lo, input int hi);
    int r;
    r = $urandom_range(99, 0);
    if (r < 15 && lo <= 12) return $urandom_range(lo + 1, (lo > 1) ? lo - 1 : 1);
    if (r < 25 && hi <= 12) return $urandom_range(hi + 1, (hi > 1) ? hi - 1 : 1);
    if (r < 40) return $urandom_range(24, 9);
    return $urandom_range(8, 1);
  endfunction

  function automatic name_end_e pick_ending();
    int r;
    r = $urandom_range(99, 0);
    if (r < 75) return END_STOP;
    if (r < 87) return END_STOP_LAST;
    return END_ON_LAST_BYTE;
  endfunction

  // one name-like run followed by its terminator
  task automatic send_name(input int len, input logic good, input name_end_e ending);
    logic [7:0] b;
    for (int i = 0; i < len; i++) begin
      b = (i == 0) ? pick_open_byte(good) : pick_tail_byte();
      send_byte(b, (i == len - 1) && (ending == END_ON_LAST_BYTE));
    end
    if (ending != END_ON_LAST_BYTE) send_byte(pick_stop_byte(), ending == END_STOP_LAST);
    name_bytes += len;
  endtask

  // mostly well-formed runs, some raw noise, idling switched now and then
  task automatic random_step(input int lo, input int hi);
    if ($urandom_range(99, 0) < 15)
      send_byte(8'($urandom_range(255, 0)), $urandom_range(15, 0) == 0);
    else
      send_name(pick_len(lo, hi), 1'($urandom_range(1, 0)), pick_ending());
    if ($urandom_range(24, 0) == 0) begin
      tx_idle_en = 1'($urandom_range(1, 0));
      rx_idle_en = 1'($urandom_range(1, 0));
    end
  endtask

  // stop offering and let every predicted name drain out
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (names_pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_limits(input int lo, input int hi);
    cfg_we    <= 1'b1;
    cfg_idx   <= CFG_MIN_LENGTH;
    cfg_wdata <= 8'(lo);
    @(posedge clk);
    cfg_idx   <= CFG_MAX_LENGTH;
    cfg_wdata <= 8'(hi);
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
  endtask

  // result side: random stall per beat, plus one long hold-off on request
  initial begin : rx_side
    int unsigned gap;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (rx_hold_req) begin
        out_stall <= 1'b1;
        repeat (RX_HOLD_CYCLES) @(posedge clk);
        rx_hold_req = 1'b0;
      end
      gap = rx_idle_en ? $urandom_range(14, 0) : 0;
      if (gap != 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!(out_valid && !out_stall) && !rx_hold_req) @(posedge clk);
    end
  end

  initial begin : stimulus
    int phase_mark;
    int spin;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    for (int p = 0; p < N_PHASES; p++) begin
      settle();
      set_limits(ph_min[p], ph_max[p]);
      tx_idle_en = 1'b1;
      rx_idle_en = 1'b1;
      phase_mark = name_bytes;
      if (p == 0) begin
        // directed: byte extremes, single-byte runs, lead and second-byte rules
        send_byte(8'h00, 1'b0);
        send_byte("a", 1'b0);
        send_byte(" ", 1'b0);
        send_byte("Q", 1'b0);
        send_byte("+", 1'b0);
        send_byte("A", 1'b0);
        send_byte("b", 1'b0);
        send_byte("9", 1'b0);
        send_byte("$", 1'b0);
        send_byte(".", 1'b0);
        // run closed by the stream end, then a run opened on the last byte
        send_byte("_", 1'b0);
        send_byte("@", 1'b0);
        send_byte("?", 1'b1);
        send_byte("?", 1'b1);
        send_byte("Z", 1'b0);
        send_byte("Z", 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte("@", 1'b0);
        send_byte("x", 1'b0);
        send_byte(",", 1'b0);
        // digits and dollar cannot open a run
        send_byte("9", 1'b0);
        send_byte("$", 1'b0);
        send_byte("z", 1'b0);
        send_byte(8'h80, 1'b1);
        send_byte(8'h20, 1'b1);
        // long result hold-off while bytes keep coming back to back
        tx_idle_en  = 1'b0;
        rx_hold_req = 1'b1;
        repeat (40) send_name($urandom_range(5, 1), 1'b1, END_STOP);
        tx_idle_en  = 1'b1;
      end
      if (p == 4) begin
        // longest reportable run, then one that saturates the counter
        send_name(254, 1'b1, END_STOP);
        send_name(256, 1'b1, END_ON_LAST_BYTE);
      end
      while (name_bytes - phase_mark < PHASE_BYTES) random_step(ph_min[p], ph_max[p]);
    end
    in_valid <= 1'b0;
    @(posedge clk);
    for (spin = 0; spin < 5000 && names_pending != 0; spin++) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (names_pending != 0)
      $display("names never delivered: %0d", names_pending);
    if (fail_count == 0 && names_pending == 0)
      $display("tb_top OK");
    else
      $display("tb_top NOT OK");
    $finish;
  end

  // run limit
  initial begin : watchdog
    #4_000_000;
    $display("tb_top NOT OK");
    $finish;
  end

endmodule
